/* sv/mm64a_pkg.sv */
// ----------------------------------------------------------------------------
// mm64a_pkg
// Constants and field layout shared by the streaming MurmurHash64A block
// and its port checker.
// ----------------------------------------------------------------------------
package mm64a_pkg;

    localparam int WORD_W  = 64;
    localparam int VB_W    = 4;
    localparam int LEN_W   = 31;
    localparam int HALF_W  = WORD_W / 2;

    // s_tdata layout: word, valid_bytes, msg_len, zero fill to whole bytes
    localparam int VB_LSB     = WORD_W;
    localparam int LEN_LSB    = VB_LSB + VB_W;
    localparam int IN_USED_W  = LEN_LSB + LEN_W;
    localparam int IN_DATA_W  = ((IN_USED_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = WORD_W;

    localparam logic [WORD_W-1:0] MIX_MUL    = 64'hc6a4_a793_5bd1_e995;
    localparam int                MIX_SHIFT  = 47;
    localparam logic [WORD_W-1:0] SEED_RESET = 64'hcafe_babe_dead_beef;

    localparam logic [HALF_W-1:0] MUL_LO = MIX_MUL[HALF_W-1:0];
    localparam logic [HALF_W-1:0] MUL_HI = MIX_MUL[WORD_W-1:HALF_W];

    // multiply sequence steps of the shared 32x32 unit
    typedef enum logic [1:0] {
        MSTEP_LL  = 2'd0,
        MSTEP_HL  = 2'd1,
        MSTEP_LH  = 2'd2,
        MSTEP_SUM = 2'd3
    } mstep_t;

    function automatic logic [WORD_W-1:0] xor_shift(input logic [WORD_W-1:0] x);
        xor_shift = x ^ (x >> MIX_SHIFT);
    endfunction

endpackage

/* sv/murmur64a_stream_hash.sv */
// ----------------------------------------------------------------------------
// murmur64a_stream_hash
// Streaming 64-bit MurmurHash64A over little-endian key words, one shared
// 32x32 multiplier stepped by a small sequencer.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  s_        in   s_tvalid/s_tready    tdata word/valid_bytes/msg_len,
//                                      tuser first, tlast last
//  m_        out  m_tvalid/m_tready    tdata hash
//  cfg_      in   cfg_valid/cfg_ready  cfg_data seed
//
//  every 64-bit multiply is stepped through the single 32x32 multiplier
//  (low*low, high*low, low*high, final add); a first item also multiplies
//  msg_len into the seed, a full word runs the key mix and hash multiply,
//  and a last item ends with the avalanche multiply and the hash hand-off.
//  s_tready is high only while idle; a finished hash sits in the output
//  register so the next item is taken while it waits.
//  reset is synchronous on aresetn low; seed returns to its default,
//  the running hash to zero.
// ----------------------------------------------------------------------------
module murmur64a_stream_hash (
    input  logic                               aclk,
    input  logic                               aresetn,
    // word [63:0], valid_bytes [67:64], msg_len [98:68], zero fill
    input  logic [mm64a_pkg::IN_DATA_W-1:0]    s_tdata,
    // first [0]
    input  logic                               s_tuser,
    input  logic                               s_tlast,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // hash [63:0]
    output logic [mm64a_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [mm64a_pkg::WORD_W-1:0]       cfg_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN,
        S_DISP,
        S_K1,
        S_K2,
        S_HMUL,
        S_AV,
        S_OUT
    } state_t;

    localparam int W = mm64a_pkg::WORD_W;
    localparam int H = mm64a_pkg::HALF_W;

    state_t                       state_reg, state_next;
    mm64a_pkg::mstep_t            step_reg, step_next;
    logic [W-1:0]                 seed_reg, seed_next;
    logic [W-1:0]                 hash_reg, hash_next;
    logic [W-1:0]                 word_reg, word_next;
    logic [mm64a_pkg::VB_W-1:0]   vb_reg, vb_next;
    logic                         last_reg, last_next;
    logic [W-1:0]                 mul_a_reg, mul_a_next;
    logic [W-1:0]                 acc_reg, acc_next;
    logic [W-1:0]                 prod_reg, prod_next;
    logic [W-1:0]                 fin_reg, fin_next;
    logic [W-1:0]                 out_reg, out_next;
    logic                         out_valid_reg, out_valid_next;

    logic [H-1:0]                 mul_x, mul_y;
    logic [W-1:0]                 mul_res;
    logic                         mul_done;
    logic [W-1:0]                 tail_mask;
    logic [W-1:0]                 tail_word;
    logic                         full_mix;
    logic                         in_acc;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tdata   = out_reg;
    assign m_tvalid  = out_valid_reg;
    assign in_acc    = s_tvalid && s_tready;

    // shared 32x32 multiplier, operand halves picked by step
    always_comb begin
        mul_x = (step_reg == mm64a_pkg::MSTEP_HL) ? mul_a_reg[W-1:H] : mul_a_reg[H-1:0];
        mul_y = (step_reg == mm64a_pkg::MSTEP_LH) ? mm64a_pkg::MUL_HI : mm64a_pkg::MUL_LO;
    end

    assign mul_res  = acc_reg + {prod_reg[H-1:0], {H{1'b0}}};
    assign mul_done = (step_reg == mm64a_pkg::MSTEP_SUM);

    // keep bytes below valid_bytes for a short tail
    always_comb begin
        for (int i = 0; i < W / 8; i++) begin
            tail_mask[i*8 +: 8] = (i < int'(vb_reg)) ? 8'hff : 8'h00;
        end
    end

    assign tail_word = word_reg & tail_mask;
    assign full_mix  = !last_reg || vb_reg[mm64a_pkg::VB_W-1];

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        seed_next      = seed_reg;
        hash_next      = hash_reg;
        word_next      = word_reg;
        vb_next        = vb_reg;
        last_next      = last_reg;
        mul_a_next     = mul_a_reg;
        acc_next       = acc_reg;
        prod_next      = {{H{1'b0}}, mul_x} * {{H{1'b0}}, mul_y};
        fin_next       = fin_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (m_tvalid && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (cfg_valid && cfg_ready) begin
            seed_next = cfg_data;
        end

        // step the multiply sequence in every multiply state
        if (state_reg == S_LEN || state_reg == S_K1 || state_reg == S_K2 ||
            state_reg == S_HMUL || state_reg == S_AV) begin
            step_next = mm64a_pkg::mstep_t'(step_reg + 2'd1);
            case (step_reg)
                mm64a_pkg::MSTEP_HL: acc_next = prod_reg;
                mm64a_pkg::MSTEP_LH: acc_next = mul_res;
                default:             acc_next = acc_reg;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    word_next  = s_tdata[W-1:0];
                    vb_next    = s_tdata[mm64a_pkg::LEN_LSB-1:mm64a_pkg::VB_LSB];
                    last_next  = s_tlast;
                    mul_a_next = {{(W - mm64a_pkg::LEN_W){1'b0}},
                                  s_tdata[mm64a_pkg::IN_USED_W-1:mm64a_pkg::LEN_LSB]};
                    state_next = s_tuser ? S_LEN : S_DISP;
                end
            end
            S_LEN: begin
                if (mul_done) begin
                    hash_next  = seed_reg ^ mul_res;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                if (full_mix) begin
                    mul_a_next = word_reg;
                    state_next = S_K1;
                end else if (vb_reg != '0) begin
                    hash_next  = hash_reg ^ tail_word;
                    mul_a_next = hash_reg ^ tail_word;
                    state_next = S_HMUL;
                end else begin
                    // empty tail: straight to the avalanche
                    mul_a_next = mm64a_pkg::xor_shift(hash_reg);
                    state_next = S_AV;
                end
            end
            S_K1: begin
                if (mul_done) begin
                    mul_a_next = mm64a_pkg::xor_shift(mul_res);
                    state_next = S_K2;
                end
            end
            S_K2: begin
                if (mul_done) begin
                    hash_next  = hash_reg ^ mul_res;
                    mul_a_next = hash_reg ^ mul_res;
                    state_next = S_HMUL;
                end
            end
            S_HMUL: begin
                if (mul_done) begin
                    hash_next = mul_res;
                    if (last_reg) begin
                        mul_a_next = mm64a_pkg::xor_shift(mul_res);
                        state_next = S_AV;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_AV: begin
                if (mul_done) begin
                    fin_next   = mm64a_pkg::xor_shift(mul_res);
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                // wait for the output register to free up
                if (!out_valid_reg || m_tready) begin
                    out_next       = fin_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            step_reg      <= mm64a_pkg::MSTEP_LL;
            seed_reg      <= mm64a_pkg::SEED_RESET;
            hash_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            seed_reg      <= seed_next;
            hash_reg      <= hash_next;
            out_valid_reg <= out_valid_next;
        end
        word_reg  <= word_next;
        vb_reg    <= vb_next;
        last_reg  <= last_next;
        mul_a_reg <= mul_a_next;
        acc_reg   <= acc_next;
        prod_reg  <= prod_next;
        fin_reg   <= fin_next;
        out_reg   <= out_next;
    end

endmodule

/* sv/mm64a_checker.sv */
// ----------------------------------------------------------------------------
// mm64a_checker
// Port-level checks for the streaming MurmurHash64A block.
// ----------------------------------------------------------------------------
module mm64a_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic [mm64a_pkg::OUT_DATA_W-1:0]   m_tdata,
    input logic                               m_tvalid,
    input logic                               m_tready
);

    // a held hash stays up until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("hash dropped before it was taken");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("hash changed while stalled");

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    // a new hash shows up only as the sequencer returns to idle
    a_out_at_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready && !$past(s_tvalid && s_tready))
        else $error("hash appeared outside the end of an item");

endmodule

bind murmur64a_stream_hash mm64a_checker u_mm64a_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
